>>> rtl/core/mips_subset_execute_defines.svh
// Assertion macros used by the execute block RTL.
`ifndef MIPS_SUBSET_EXECUTE_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define MSE_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("mips_subset_execute: check failed");

// Same-cycle implication.
`define MSE_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mips_subset_execute: implication failed");

// Next-cycle implication.
`define MSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mips_subset_execute: next-cycle check failed");

`endif

>>> rtl/core/mse_pkg.sv
// Package: widths, opcodes, status codes and result type for the execute block.
`timescale 1ns / 1ps
package mse_pkg;

   localparam int INDEX_WIDTH     = 26;
   localparam int NEXT_INDEX_BITS = 26;
   localparam int DATA_BITS       = 32;
   localparam int INSTR_BITS      = 32;
   localparam int REG_COUNT       = 32;
   localparam int REG_ADDR_BITS   = $clog2(REG_COUNT);
   localparam int SHAMT_BITS      = 5;
   localparam int OPCODE_BITS     = 6;
   localparam int FUNCT_BITS      = 6;
   localparam int IMM_BITS        = 16;

   localparam logic [REG_ADDR_BITS-1:0] LINK_REG = REG_ADDR_BITS'(31);

   localparam logic [OPCODE_BITS-1:0] OP_RTYPE  = 6'h00;
   localparam logic [OPCODE_BITS-1:0] OP_REGIMM = 6'h01;
   localparam logic [OPCODE_BITS-1:0] OP_J      = 6'h02;
   localparam logic [OPCODE_BITS-1:0] OP_JAL    = 6'h03;
   localparam logic [OPCODE_BITS-1:0] OP_BEQ    = 6'h04;
   localparam logic [OPCODE_BITS-1:0] OP_BNE    = 6'h05;
   localparam logic [OPCODE_BITS-1:0] OP_BLEZ   = 6'h06;
   localparam logic [OPCODE_BITS-1:0] OP_BGTZ   = 6'h07;
   localparam logic [OPCODE_BITS-1:0] OP_ADDI   = 6'h08;
   localparam logic [OPCODE_BITS-1:0] OP_ADDIU  = 6'h09;
   localparam logic [OPCODE_BITS-1:0] OP_SLTI   = 6'h0A;
   localparam logic [OPCODE_BITS-1:0] OP_SLTIU  = 6'h0B;

   localparam logic [FUNCT_BITS-1:0] FN_SLL     = 6'h00;
   localparam logic [FUNCT_BITS-1:0] FN_SRL     = 6'h02;
   localparam logic [FUNCT_BITS-1:0] FN_JR      = 6'h08;
   localparam logic [FUNCT_BITS-1:0] FN_SYSCALL = 6'h0C;
   localparam logic [FUNCT_BITS-1:0] FN_ADD     = 6'h20;
   localparam logic [FUNCT_BITS-1:0] FN_ADDU    = 6'h21;
   localparam logic [FUNCT_BITS-1:0] FN_SUB     = 6'h22;
   localparam logic [FUNCT_BITS-1:0] FN_SLT     = 6'h2A;
   localparam logic [FUNCT_BITS-1:0] FN_SLTU    = 6'h2B;

   localparam logic [REG_ADDR_BITS-1:0] RT_BLTZ = REG_ADDR_BITS'(0);
   localparam logic [REG_ADDR_BITS-1:0] RT_BGEZ = REG_ADDR_BITS'(1);

   typedef enum logic [1:0] {
      STATUS_EXECUTED    = 2'd0,
      STATUS_SYSCALL     = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } mse_status_type;

   typedef struct packed {
      logic [NEXT_INDEX_BITS-1:0] next_index;
      logic                       write_enable;
      logic [REG_ADDR_BITS-1:0]   write_reg;
      logic [DATA_BITS-1:0]       write_value;
      mse_status_type             status;
   } mse_result_type;

endpackage

>>> rtl/core/mse_channels.sv
// Valid/ready channel interfaces for instruction requests and execute responses.
`timescale 1ns / 1ps
interface mse_req_if import mse_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [INSTR_BITS-1:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink (input valid, input instr_word, output ready);
endinterface

interface mse_rsp_if import mse_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [NEXT_INDEX_BITS-1:0] next_index;
   logic                       write_enable;
   logic [REG_ADDR_BITS-1:0]   write_reg;
   logic [DATA_BITS-1:0]       write_value;
   logic [1:0]                 status;

   modport source (output valid, output next_index, output write_enable,
                   output write_reg, output write_value, output status, input ready);
   modport sink (input valid, input next_index, input write_enable,
                 input write_reg, input write_value, input status, output ready);
endinterface

>>> rtl/core/mse_regfile.sv
// Register file: 32x32 memory, one write and two registered reads, valid bits for reset.
`timescale 1ns / 1ps
module mse_regfile import mse_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [REG_ADDR_BITS-1:0] rd_addr_a,
   input  logic [REG_ADDR_BITS-1:0] rd_addr_b,
   input  logic                     wr_en,
   input  logic [REG_ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   output logic [DATA_BITS-1:0]     rd_data_a,
   output logic [DATA_BITS-1:0]     rd_data_b
);

   logic [DATA_BITS-1:0] regs_ff [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [REG_COUNT-1:0] valid_in;
   logic [DATA_BITS-1:0] data_a_ff;
   logic [DATA_BITS-1:0] data_b_ff;
   logic                 ok_a_ff;
   logic                 ok_b_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regs_ff[wr_addr] <= wr_data;
      end
   end

   // old data on read-during-write; caller bypasses
   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= regs_ff[rd_addr_a];
         data_b_ff <= regs_ff[rd_addr_b];
         ok_a_ff   <= valid_ff[rd_addr_a];
         ok_b_ff   <= valid_ff[rd_addr_b];
      end
   end

   assign rd_data_a = ok_a_ff ? data_a_ff : '0;
   assign rd_data_b = ok_b_ff ? data_b_ff : '0;

endmodule

>>> rtl/core/mse_exec.sv
// Execute unit: decodes one instruction and computes next index, write-back and status.
`timescale 1ns / 1ps
module mse_exec import mse_pkg::*; (
   input  logic [INSTR_BITS-1:0]  instr_word,
   input  logic [DATA_BITS-1:0]   op_a,
   input  logic [DATA_BITS-1:0]   op_b,
   input  logic [INDEX_WIDTH-1:0] instr_index,
   output mse_result_type         result
);

   logic [OPCODE_BITS-1:0]   opcode;
   logic [REG_ADDR_BITS-1:0] rt;
   logic [REG_ADDR_BITS-1:0] rd;
   logic [SHAMT_BITS-1:0]    shamt;
   logic [FUNCT_BITS-1:0]    funct;
   logic [DATA_BITS-1:0]     simm;
   logic [INDEX_WIDTH-1:0]   seq_index;
   logic [INDEX_WIDTH-1:0]   branch_tgt;
   logic [INDEX_WIDTH-1:0]   jump_tgt;
   logic [INDEX_WIDTH-1:0]   next_idx;
   logic                     we_raw;
   logic [REG_ADDR_BITS-1:0] wr_raw;
   logic [DATA_BITS-1:0]     wv_raw;
   mse_status_type           status;
   logic                     a_neg;
   logic                     a_zero;

   assign opcode     = instr_word[31:26];
   assign rt         = instr_word[20:16];
   assign rd         = instr_word[15:11];
   assign shamt      = instr_word[10:6];
   assign funct      = instr_word[5:0];
   assign simm       = {{(DATA_BITS-IMM_BITS){instr_word[IMM_BITS-1]}},
                        instr_word[IMM_BITS-1:0]};
   assign seq_index  = instr_index + INDEX_WIDTH'(1);
   assign branch_tgt = simm[INDEX_WIDTH-1:0];
   assign jump_tgt   = instr_word[INDEX_WIDTH-1:0];
   assign a_neg      = op_a[DATA_BITS-1];
   assign a_zero     = (op_a == '0);

   always_comb begin
      we_raw   = 1'b0;
      wr_raw   = rd;
      wv_raw   = '0;
      next_idx = seq_index;
      status   = STATUS_EXECUTED;
      unique case (opcode)
         OP_RTYPE: begin
            unique case (funct)
               FN_ADD, FN_ADDU: begin
                  we_raw = 1'b1;
                  wv_raw = op_a + op_b;
               end
               FN_SUB: begin
                  we_raw = 1'b1;
                  wv_raw = op_a - op_b;
               end
               FN_SLT: begin
                  we_raw = 1'b1;
                  wv_raw = DATA_BITS'($signed(op_a) < $signed(op_b));
               end
               FN_SLTU: begin
                  we_raw = 1'b1;
                  wv_raw = DATA_BITS'(op_a < op_b);
               end
               FN_SLL: begin
                  we_raw = 1'b1;
                  wv_raw = op_b << shamt;
               end
               FN_SRL: begin
                  we_raw = 1'b1;
                  wv_raw = op_b >> shamt;
               end
               FN_JR: begin
                  next_idx = op_a[INDEX_WIDTH-1:0];
               end
               FN_SYSCALL: begin
                  status = STATUS_SYSCALL;
               end
               default: begin
                  status = STATUS_UNSUPPORTED;
               end
            endcase
         end
         OP_J: begin
            next_idx = jump_tgt;
         end
         OP_JAL: begin
            we_raw   = 1'b1;
            wr_raw   = LINK_REG;
            wv_raw   = DATA_BITS'(seq_index);
            next_idx = jump_tgt;
         end
         OP_BEQ: begin
            if (op_a == op_b) begin
               next_idx = branch_tgt;
            end
         end
         OP_BNE: begin
            if (op_a != op_b) begin
               next_idx = branch_tgt;
            end
         end
         OP_BLEZ: begin
            if (a_neg || a_zero) begin
               next_idx = branch_tgt;
            end
         end
         OP_BGTZ: begin
            if (!a_neg && !a_zero) begin
               next_idx = branch_tgt;
            end
         end
         OP_REGIMM: begin
            priority if (rt == RT_BLTZ) begin
               if (a_neg) begin
                  next_idx = branch_tgt;
               end
            end else if (rt == RT_BGEZ) begin
               if (!a_neg) begin
                  next_idx = branch_tgt;
               end
            end else begin
               status = STATUS_UNSUPPORTED;
            end
         end
         OP_ADDI, OP_ADDIU: begin
            we_raw = 1'b1;
            wr_raw = rt;
            wv_raw = op_a + simm;
         end
         OP_SLTI: begin
            we_raw = 1'b1;
            wr_raw = rt;
            wv_raw = DATA_BITS'($signed(op_a) < $signed(simm));
         end
         OP_SLTIU: begin
            we_raw = 1'b1;
            wr_raw = rt;
            wv_raw = DATA_BITS'(op_a < simm);
         end
         default: begin
            status = STATUS_UNSUPPORTED;
         end
      endcase
   end

   // writes to r0 are dropped and reported as no write
   always_comb begin
      result.next_index = NEXT_INDEX_BITS'(next_idx);
      result.status     = status;
      if (we_raw && (wr_raw != '0)) begin
         result.write_enable = 1'b1;
         result.write_reg    = wr_raw;
         result.write_value  = wv_raw;
      end else begin
         result.write_enable = 1'b0;
         result.write_reg    = '0;
         result.write_value  = '0;
      end
   end

endmodule

>>> rtl/core/mips_subset_execute.sv
// Top level: MIPS integer subset execute block with register file and instruction index.
`timescale 1ns / 1ps
// Executes one 32-bit MIPS instruction per transfer on req_chan and returns one
// response per instruction on rsp_chan: the next instruction index, the register
// write (if any) and a status (executed, syscall seen, unsupported no-op). The
// block holds the 32x32 register file (zero after reset) and the current index.
// Throughput is one instruction per cycle unless rsp_chan stalls; from request
// transfer to response valid, the register file read is registered with the
// instruction, then the execute logic feeds the response register. Back-to-back
// dependent instructions are covered by a bypass from the committing instruction.
// Register file and index are updated when an instruction moves to the response
// register, so state changes stay in instruction order under any stall pattern.
`include "mips_subset_execute_defines.svh"
module mips_subset_execute import mse_pkg::*; (
   input logic       clock,
   input logic       reset,
   mse_req_if.sink   req_chan,
   mse_rsp_if.source rsp_chan
);

   logic                     accept;
   logic                     commit;
   logic                     s1_valid_ff;
   logic                     s1_valid_in;
   logic [INSTR_BITS-1:0]    s1_instr_ff;
   logic                     s1_byp_a_ff;
   logic                     s1_byp_b_ff;
   logic [DATA_BITS-1:0]     s1_byp_val_ff;
   logic                     byp_a_in;
   logic                     byp_b_in;
   logic [INDEX_WIDTH-1:0]   index_ff;
   logic [INDEX_WIDTH-1:0]   index_in;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   mse_result_type           out_res_ff;
   mse_result_type           exec_res;
   logic [DATA_BITS-1:0]     rf_a;
   logic [DATA_BITS-1:0]     rf_b;
   logic [DATA_BITS-1:0]     op_a;
   logic [DATA_BITS-1:0]     op_b;
   logic [REG_ADDR_BITS-1:0] req_rs;
   logic [REG_ADDR_BITS-1:0] req_rt;

   assign commit         = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || commit;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_rs = req_chan.instr_word[25:21];
   assign req_rt = req_chan.instr_word[20:16];

   mse_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_rs),
      .rd_addr_b (req_rt),
      .wr_en     (commit && exec_res.write_enable),
      .wr_addr   (exec_res.write_reg),
      .wr_data   (exec_res.write_value),
      .rd_data_a (rf_a),
      .rd_data_b (rf_b)
   );

   // forward the write retiring in the same cycle as the read
   assign byp_a_in = commit && exec_res.write_enable && (exec_res.write_reg == req_rs);
   assign byp_b_in = commit && exec_res.write_enable && (exec_res.write_reg == req_rt);

   assign op_a = s1_byp_a_ff ? s1_byp_val_ff : rf_a;
   assign op_b = s1_byp_b_ff ? s1_byp_val_ff : rf_b;

   mse_exec u_exec (
      .instr_word  (s1_instr_ff),
      .op_a        (op_a),
      .op_b        (op_b),
      .instr_index (index_ff),
      .result      (exec_res)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      out_valid_in = out_valid_ff;
      index_in     = index_ff;
      if (commit) begin
         s1_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         index_in     = exec_res.next_index[INDEX_WIDTH-1:0];
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         index_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         index_ff     <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff   <= req_chan.instr_word;
         s1_byp_a_ff   <= byp_a_in;
         s1_byp_b_ff   <= byp_b_in;
         s1_byp_val_ff <= exec_res.write_value;
      end
      if (commit) begin
         out_res_ff <= exec_res;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.next_index   = out_res_ff.next_index;
   assign rsp_chan.write_enable = out_res_ff.write_enable;
   assign rsp_chan.write_reg    = out_res_ff.write_reg;
   assign rsp_chan.write_value  = out_res_ff.write_value;
   assign rsp_chan.status       = out_res_ff.status;

   `MSE_ASSERT_IMPLY(a_no_write_zeroed, out_valid_ff && !out_res_ff.write_enable, out_res_ff.write_reg == '0 && out_res_ff.write_value == '0)
   `MSE_ASSERT_IMPLY(a_no_r0_write, commit && exec_res.write_enable, exec_res.write_reg != '0)
   `MSE_ASSERT_NEXT(a_index_tracks_rsp, commit, out_valid_ff && index_ff == out_res_ff.next_index[INDEX_WIDTH-1:0])
   `MSE_ASSERT_IMPLY(a_status_no_write, out_valid_ff && out_res_ff.status != STATUS_EXECUTED, !out_res_ff.write_enable)

endmodule

>>> sim/mips_subset_execute_tb.sv
// Testbench for mips_subset_execute: checks each transfer against an instruction-level model.
`timescale 1ns / 1ps
module mips_subset_execute_tb;
   import mse_pkg::*;

   localparam logic [OPCODE_BITS-1:0]   OP_LW    = 6'h23;
   localparam logic [FUNCT_BITS-1:0]    FN_UNDEF = 6'h3F;
   localparam logic [REG_ADDR_BITS-1:0] RT_UNDEF = 5'd2;

   logic clock;
   logic reset;

   mse_req_if req_chan ();
   mse_rsp_if rsp_chan ();

   mips_subset_execute u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [DATA_BITS-1:0]   gpr [REG_COUNT];
   logic [INDEX_WIDTH-1:0] cur_index;
   mse_result_type         pending_results [$];
   mse_result_type         exp_rsp;
   int                     error_count;
   bit                     idle_on;
   int                     hold_request;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic [INSTR_BITS-1:0] r_type(input logic [4:0] rs, input logic [4:0] rt,
         input logic [4:0] rd, input logic [4:0] sh, input logic [FUNCT_BITS-1:0] fn);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [INSTR_BITS-1:0] i_type(input logic [OPCODE_BITS-1:0] op,
         input logic [4:0] rs, input logic [4:0] rt, input logic [IMM_BITS-1:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [INSTR_BITS-1:0] j_type(input logic [OPCODE_BITS-1:0] op,
         input logic [25:0] tgt);
      return {op, tgt};
   endfunction

   // Executes one instruction on the shadow register file and index.
   function automatic mse_result_type execute_instr(input logic [INSTR_BITS-1:0] w);
      logic [OPCODE_BITS-1:0] op;
      logic [FUNCT_BITS-1:0]  fn;
      logic [4:0]             rs, rt, rd, sh, wr;
      logic [DATA_BITS-1:0]   a, b, simm, wv;
      logic [INDEX_WIDTH-1:0] seq, nxt, btgt;
      logic                   we;
      mse_status_type         st;
      mse_result_type         r;
      op   = w[31:26];
      rs   = w[25:21];
      rt   = w[20:16];
      rd   = w[15:11];
      sh   = w[10:6];
      fn   = w[5:0];
      simm = {{16{w[15]}}, w[15:0]};
      a    = (rs == 0) ? '0 : gpr[rs];
      b    = (rt == 0) ? '0 : gpr[rt];
      seq  = cur_index + 1'b1;
      nxt  = seq;
      btgt = simm[INDEX_WIDTH-1:0];
      we   = 1'b0;
      wr   = '0;
      wv   = '0;
      st   = STATUS_EXECUTED;
      case (op)
         OP_RTYPE: begin
            case (fn)
               FN_ADD, FN_ADDU: begin we = 1'b1; wr = rd; wv = a + b; end
               FN_SUB: begin we = 1'b1; wr = rd; wv = a - b; end
               FN_SLT: begin we = 1'b1; wr = rd; wv = 32'($signed(a) < $signed(b)); end
               FN_SLTU: begin we = 1'b1; wr = rd; wv = 32'(a < b); end
               FN_SLL: begin we = 1'b1; wr = rd; wv = b << sh; end
               FN_SRL: begin we = 1'b1; wr = rd; wv = b >> sh; end
               FN_JR: nxt = a[INDEX_WIDTH-1:0];
               FN_SYSCALL: st = STATUS_SYSCALL;
               default: st = STATUS_UNSUPPORTED;
            endcase
         end
         OP_J: nxt = w[INDEX_WIDTH-1:0];
         OP_JAL: begin
            we  = 1'b1;
            wr  = LINK_REG;
            wv  = 32'(seq);
            nxt = w[INDEX_WIDTH-1:0];
         end
         OP_BEQ: if (a == b) nxt = btgt;
         OP_BNE: if (a != b) nxt = btgt;
         OP_BLEZ: if (a[31] || a == 0) nxt = btgt;
         OP_BGTZ: if (!a[31] && a != 0) nxt = btgt;
         OP_REGIMM: begin
            if (rt == RT_BLTZ) begin
               if (a[31]) nxt = btgt;
            end else if (rt == RT_BGEZ) begin
               if (!a[31]) nxt = btgt;
            end else begin
               st = STATUS_UNSUPPORTED;
            end
         end
         OP_ADDI, OP_ADDIU: begin we = 1'b1; wr = rt; wv = a + simm; end
         OP_SLTI: begin we = 1'b1; wr = rt; wv = 32'($signed(a) < $signed(simm)); end
         OP_SLTIU: begin we = 1'b1; wr = rt; wv = 32'(a < simm); end
         default: st = STATUS_UNSUPPORTED;
      endcase
      if (we && wr == 0) we = 1'b0;
      if (we) begin
         gpr[wr] = wv;
      end else begin
         wr = '0;
         wv = '0;
      end
      cur_index      = nxt;
      r.next_index   = NEXT_INDEX_BITS'(nxt);
      r.write_enable = we;
      r.write_reg    = wr;
      r.write_value  = wv;
      r.status       = st;
      return r;
   endfunction

   function automatic logic [4:0] pick_reg();
      // mostly low registers so results feed later instructions
      return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
   endfunction

   function automatic logic [IMM_BITS-1:0] pick_imm();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [INSTR_BITS-1:0] random_instr();
      int unsigned            pick;
      logic [FUNCT_BITS-1:0]  fn;
      logic [OPCODE_BITS-1:0] op;
      logic [4:0]             rt;
      pick = $urandom_range(0, 99);
      if (pick < 8) return $urandom();
      if (pick < 50) begin
         case ($urandom_range(0, 9))
            0: fn = FN_SLL;
            1: fn = FN_SRL;
            2: fn = FN_JR;
            3: fn = FN_SYSCALL;
            4: fn = FN_ADD;
            5: fn = FN_ADDU;
            6: fn = FN_SUB;
            7: fn = FN_SLT;
            8: fn = FN_SLTU;
            default: fn = 6'($urandom_range(0, 63));
         endcase
         return r_type(pick_reg(), pick_reg(), pick_reg(), 5'($urandom_range(0, 31)), fn);
      end
      if (pick < 82) begin
         case ($urandom_range(0, 3))
            0: op = OP_ADDI;
            1: op = OP_ADDIU;
            2: op = OP_SLTI;
            default: op = OP_SLTIU;
         endcase
         return i_type(op, pick_reg(), pick_reg(), pick_imm());
      end
      if (pick < 96) begin
         rt = pick_reg();
         case ($urandom_range(0, 4))
            0: op = OP_BEQ;
            1: op = OP_BNE;
            2: op = OP_BLEZ;
            3: op = OP_BGTZ;
            default: begin
               op = OP_REGIMM;
               if ($urandom_range(0, 5) != 0) rt = $urandom_range(0, 1) ? RT_BGEZ : RT_BLTZ;
            end
         endcase
         return i_type(op, pick_reg(), rt, pick_imm());
      end
      return j_type($urandom_range(0, 1) ? OP_JAL : OP_J, 26'($urandom()));
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      $display("%0t: mismatch %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   // request transfers are modelled first, then response transfers are checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            pending_results.push_back(execute_instr(req_chan.instr_word));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with no instruction", 32'(rsp_chan.next_index), '0);
            end else begin
               exp_rsp = pending_results.pop_front();
               if (rsp_chan.next_index !== exp_rsp.next_index)
                  report_mismatch("next_index", 32'(rsp_chan.next_index),
                                  32'(exp_rsp.next_index));
               if (rsp_chan.write_enable !== exp_rsp.write_enable)
                  report_mismatch("write_enable", 32'(rsp_chan.write_enable),
                                  32'(exp_rsp.write_enable));
               if (rsp_chan.write_reg !== exp_rsp.write_reg)
                  report_mismatch("write_reg", 32'(rsp_chan.write_reg), 32'(exp_rsp.write_reg));
               if (rsp_chan.write_value !== exp_rsp.write_value)
                  report_mismatch("write_value", rsp_chan.write_value, exp_rsp.write_value);
               if (rsp_chan.status !== exp_rsp.status)
                  report_mismatch("status", 32'(rsp_chan.status), 32'(exp_rsp.status));
            end
         end
      end
   end

   // response ready: random stalls, plus long holds on request
   initial begin
      int n;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_chan.ready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            rsp_chan.ready <= 1'b0;
            repeat (n) @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // valid stays high across back-to-back transfers; dropped only for a gap
   task automatic send_instr(input logic [INSTR_BITS-1:0] w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.instr_word <= w;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic test_directed_alu();
      logic [INSTR_BITS-1:0] prog [$];
      prog = '{
         i_type(OP_ADDIU, 0, 1, 16'h7FFF),
         i_type(OP_ADDI, 0, 2, 16'h8000),
         r_type(0, 2, 3, 16, FN_SLL),
         r_type(3, 3, 5, 0, FN_ADD),
         i_type(OP_ADDIU, 0, 6, 16'hFFFF),
         r_type(3, 1, 8, 0, FN_SUB),
         r_type(3, 1, 9, 0, FN_SLT),
         r_type(3, 1, 10, 0, FN_SLTU),
         i_type(OP_SLTI, 6, 11, 16'h0000),
         i_type(OP_SLTIU, 1, 12, 16'hFFFF),
         r_type(0, 6, 13, 31, FN_SRL),
         r_type(1, 1, 0, 7, FN_ADD)
      };
      idle_on = 1'b1;
      foreach (prog[i]) send_instr(prog[i]);
   endtask

   task automatic test_directed_flow();
      logic [INSTR_BITS-1:0] prog [$];
      prog = '{
         i_type(OP_BEQ, 1, 1, 16'hFFFF),
         i_type(OP_BNE, 1, 1, 16'h0005),
         i_type(OP_REGIMM, 3, RT_BLTZ, 16'h8000),
         i_type(OP_REGIMM, 3, RT_BGEZ, 16'h0010),
         i_type(OP_REGIMM, 1, RT_UNDEF, 16'h0030),
         i_type(OP_BGTZ, 1, 9, 16'h0040),
         i_type(OP_BLEZ, 0, 0, 16'h0050),
         j_type(OP_J, 26'h3FFFFFF),
         j_type(OP_JAL, 26'h0000010),
         r_type(6, 0, 0, 0, FN_JR),
         r_type(0, 0, 0, 0, FN_SYSCALL),
         i_type(OP_LW, 1, 2, 16'h0000),
         r_type(1, 1, 3, 0, FN_UNDEF)
      };
      foreach (prog[i]) send_instr(prog[i]);
   endtask

   task automatic test_random();
      for (int chunk = 0; chunk < 10; chunk++) begin
         idle_on = (chunk % 3 != 2);
         repeat (100) send_instr(random_instr());
      end
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_request = 60;
      repeat (40) send_instr(random_instr());
   endtask

   task automatic test_no_idle();
      idle_on = 1'b0;
      repeat (100) send_instr(random_instr());
   endtask

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.instr_word = '0;
      idle_on             = 1'b0;
      hold_request        = 0;
      error_count         = 0;
      cur_index           = '0;
      foreach (gpr[i]) gpr[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_alu();
      test_directed_flow();
      test_random();
      test_backpressure();
      test_no_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> mips_subset_execute.f
+incdir+rtl/core
rtl/core/mse_pkg.sv
rtl/core/mse_channels.sv
rtl/core/mse_regfile.sv
rtl/core/mse_exec.sv
rtl/core/mips_subset_execute.sv
sim/mips_subset_execute_tb.sv
